### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit: operation and status
// codes, controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIVZERO  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_P,
      S_MUL_Q,
      S_MUL_D,
      S_COMB,
      S_GCD,
      S_DIV,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_P,
      MUL_Q,
      MUL_D
   } mul_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_DIVZERO,
      RES_CMP,
      RES_ARITH
   } res_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        combine;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        res_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic op_valid;
      logic is_cmp;
      logic den_zero;
      logic div_by_zero;
      logic gcd_done;
   } stat_type;

endpackage

### rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared multiplier, binary GCD unit, twin restoring
// dividers for the exact reduction, and the result register.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int WORD_WIDTH = 32
) (
   input  logic             clock,
   input  rau_pkg::cmd_type cmd,
   output rau_pkg::stat_type stat,
   input  logic [127:0]     req_tdata,
   input  logic [2:0]       req_tuser,
   output logic [71:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser
);

   localparam int W  = WORD_WIDTH;
   localparam int DW = 2 * WORD_WIDTH;
   localparam int KW = $clog2(DW + 1);
   localparam logic [DW-1:0] LIM  = DW'(1) << (W - 1);
   localparam logic [DW-1:0] WMAX = (DW'(1) << W) - DW'(1);

   logic [2:0]    op_ff;
   logic [W-1:0]  am_ff, bm_ff, ad_ff, bd_ff;
   logic          as_ff, bs_ff;
   logic [W-1:0]  a_w, b_w;
   logic [W-1:0]  am_in, bm_in;

   logic [W-1:0]  mul_x, mul_y;
   logic [DW-1:0] product;
   logic [DW-1:0] p_ff, q_ff, d_ff;

   logic          neg_ff, neg_in;
   logic          qs;
   logic [DW-1:0] mag_in;

   logic [DW-1:0] u_ff, v_ff, u_in, v_in;
   logic [KW-1:0] k_ff, k_in;

   logic [DW-1:0] g_ff;
   logic [DW-1:0] rem_n_ff, quo_n_ff, rem_d_ff, quo_d_ff;
   logic [DW:0]   trial_n, trial_d;
   logic          fits_n, fits_d;
   logic [DW-1:0] rem_n_in, rem_d_in;

   logic          cmp_eq, cmp_less, ovf;
   logic [32:0]   num_ext, den_ext;
   logic [31:0]   num_out;

   logic [31:0]   res_num_ff, res_den_ff;
   logic          eq_ff, less_ff;
   logic [1:0]    status_ff;
   logic [31:0]   res_num_in, res_den_in;
   logic          eq_in, less_in;
   logic [1:0]    status_in;

   assign a_w   = req_tdata[W-1:0];
   assign b_w   = req_tdata[64+W-1:64];
   assign am_in = a_w[W-1] ? (W'(0) - a_w) : a_w;
   assign bm_in = b_w[W-1] ? (W'(0) - b_w) : b_w;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_tuser;
         am_ff <= am_in;
         as_ff <= a_w[W-1];
         ad_ff <= req_tdata[32+W-1:32];
         bm_ff <= bm_in;
         bs_ff <= b_w[W-1];
         bd_ff <= req_tdata[96+W-1:96];
      end
   end

   assign stat.op_valid    = (op_ff == rau_pkg::OP_ADD) || (op_ff == rau_pkg::OP_SUB) ||
                             (op_ff == rau_pkg::OP_MUL) || (op_ff == rau_pkg::OP_DIV) ||
                             (op_ff == rau_pkg::OP_CMP);
   assign stat.is_cmp      = (op_ff == rau_pkg::OP_CMP);
   assign stat.den_zero    = (ad_ff == '0) || (bd_ff == '0);
   assign stat.div_by_zero = (op_ff == rau_pkg::OP_DIV) && (bm_ff == '0);
   assign stat.gcd_done    = (u_ff == '0);

   always_comb begin
      mul_x = am_ff;
      mul_y = bd_ff;
      unique case (cmd.mul_sel)
         rau_pkg::MUL_P: begin
            mul_x = am_ff;
            mul_y = (op_ff == rau_pkg::OP_MUL) ? bm_ff : bd_ff;
         end
         rau_pkg::MUL_Q: begin
            mul_x = bm_ff;
            mul_y = ad_ff;
         end
         rau_pkg::MUL_D: begin
            mul_x = ad_ff;
            mul_y = (op_ff == rau_pkg::OP_DIV) ? bm_ff : bd_ff;
         end
         rau_pkg::MUL_NONE: begin
            mul_x = am_ff;
            mul_y = bd_ff;
         end
         default: begin
            mul_x = am_ff;
            mul_y = bd_ff;
         end
      endcase
   end

   assign product = DW'(mul_x) * DW'(mul_y);

   // The numerator product is replaced by the combined magnitude before the GCD.
   always_ff @(posedge clock) begin
      if (cmd.mul_sel == rau_pkg::MUL_P) begin
         p_ff <= product;
      end else if (cmd.combine) begin
         p_ff <= mag_in;
      end
      if (cmd.mul_sel == rau_pkg::MUL_Q) q_ff <= product;
      if (cmd.mul_sel == rau_pkg::MUL_D) d_ff <= product;
   end

   // Signed cross-product sum or difference as sign and magnitude, else p_ff, as^bs.
   always_comb begin
      qs     = (op_ff == rau_pkg::OP_SUB) ? !bs_ff : bs_ff;
      neg_in = as_ff ^ bs_ff;
      mag_in = p_ff;
      if ((op_ff == rau_pkg::OP_ADD) || (op_ff == rau_pkg::OP_SUB)) begin
         priority if (as_ff == qs) begin
            neg_in = as_ff;
            mag_in = p_ff + q_ff;
         end else if (p_ff >= q_ff) begin
            neg_in = as_ff;
            mag_in = p_ff - q_ff;
         end else begin
            neg_in = qs;
            mag_in = q_ff - p_ff;
         end
      end
   end

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      priority if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + KW'(1);
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = (u_ff - v_ff) >> 1;
      end else begin
         v_in = (v_ff - u_ff) >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.combine) begin
         neg_ff <= neg_in;
         u_ff   <= mag_in;
         v_ff   <= d_ff;
         k_ff   <= '0;
      end else if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
   end

   assign trial_n  = {rem_n_ff, quo_n_ff[DW-1]};
   assign trial_d  = {rem_d_ff, quo_d_ff[DW-1]};
   assign fits_n   = trial_n >= {1'b0, g_ff};
   assign fits_d   = trial_d >= {1'b0, g_ff};
   assign rem_n_in = fits_n ? DW'(trial_n - {1'b0, g_ff}) : trial_n[DW-1:0];
   assign rem_d_in = fits_d ? DW'(trial_d - {1'b0, g_ff}) : trial_d[DW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         g_ff     <= v_ff << k_ff;
         rem_n_ff <= '0;
         rem_d_ff <= '0;
         quo_n_ff <= p_ff;
         quo_d_ff <= d_ff;
      end else if (cmd.div_step) begin
         rem_n_ff <= rem_n_in;
         rem_d_ff <= rem_d_in;
         quo_n_ff <= {quo_n_ff[DW-2:0], fits_n};
         quo_d_ff <= {quo_d_ff[DW-2:0], fits_d};
      end
   end

   assign cmp_eq   = (as_ff == bs_ff) && (p_ff == q_ff);
   assign cmp_less = (as_ff && !bs_ff) || (!as_ff && !bs_ff && (p_ff < q_ff)) ||
                     (as_ff && bs_ff && (p_ff > q_ff));

   assign ovf     = (neg_ff ? (quo_n_ff > LIM) : (quo_n_ff > (LIM - DW'(1)))) ||
                    (quo_d_ff > WMAX);
   assign num_ext = {{(33 - W){1'b0}}, quo_n_ff[W-1:0]};
   assign den_ext = {{(33 - W){1'b0}}, quo_d_ff[W-1:0]};
   assign num_out = neg_ff ? (32'd0 - num_ext[31:0]) : num_ext[31:0];

   always_comb begin
      res_num_in = '0;
      res_den_in = '0;
      eq_in      = 1'b0;
      less_in    = 1'b0;
      status_in  = rau_pkg::ST_OK;
      unique case (cmd.res_sel)
         rau_pkg::RES_ZERO: begin
            status_in = rau_pkg::ST_OK;
         end
         rau_pkg::RES_DIVZERO: begin
            status_in = rau_pkg::ST_DIVZERO;
         end
         rau_pkg::RES_CMP: begin
            eq_in   = cmp_eq;
            less_in = cmp_less;
         end
         rau_pkg::RES_ARITH: begin
            if (ovf) begin
               status_in = rau_pkg::ST_OVERFLOW;
            end else begin
               res_num_in = num_out;
               res_den_in = den_ext[31:0];
            end
         end
         default: begin
            status_in = rau_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_num_ff <= res_num_in;
         res_den_ff <= res_den_in;
         eq_ff      <= eq_in;
         less_ff    <= less_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_tdata = {6'b0, less_ff, eq_ff, res_den_ff, res_num_ff};
   assign rsp_tuser = status_ff;

endmodule

### rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer of the rational arithmetic unit: steps the datapath through
// decode, the three products, the GCD loop and the exact division, and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module rau_ctrl #(
   parameter int WORD_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  rau_pkg::stat_type stat,
   output rau_pkg::cmd_type  cmd
);

   localparam int DW = 2 * WORD_WIDTH;
   localparam int CW = $clog2(DW);

   rau_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.mul_sel  = rau_pkg::MUL_NONE;
      cmd.res_sel  = rau_pkg::RES_ZERO;
      req_tready   = 1'b0;
      unique case (state_ff)
         rau_pkg::S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = rau_pkg::S_DECODE;
            end
         end
         rau_pkg::S_DECODE: begin
            if (!stat.op_valid || stat.den_zero || stat.div_by_zero) begin
               state_in = rau_pkg::S_EMIT;
            end else begin
               state_in = rau_pkg::S_MUL_P;
            end
         end
         rau_pkg::S_MUL_P: begin
            cmd.mul_sel = rau_pkg::MUL_P;
            state_in    = rau_pkg::S_MUL_Q;
         end
         rau_pkg::S_MUL_Q: begin
            cmd.mul_sel = rau_pkg::MUL_Q;
            state_in    = stat.is_cmp ? rau_pkg::S_EMIT : rau_pkg::S_MUL_D;
         end
         rau_pkg::S_MUL_D: begin
            cmd.mul_sel = rau_pkg::MUL_D;
            state_in    = rau_pkg::S_COMB;
         end
         rau_pkg::S_COMB: begin
            cmd.combine = 1'b1;
            state_in    = rau_pkg::S_GCD;
         end
         rau_pkg::S_GCD: begin
            if (stat.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = rau_pkg::S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         rau_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               state_in = rau_pkg::S_EMIT;
            end
         end
         rau_pkg::S_EMIT: begin
            priority if (!stat.op_valid) begin
               cmd.res_sel = rau_pkg::RES_ZERO;
            end else if (stat.den_zero || stat.div_by_zero) begin
               cmd.res_sel = rau_pkg::RES_DIVZERO;
            end else if (stat.is_cmp) begin
               cmd.res_sel = rau_pkg::RES_CMP;
            end else begin
               cmd.res_sel = rau_pkg::RES_ARITH;
            end
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.res_load = 1'b1;
               state_in     = rau_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rau_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/rational_arith_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_top
// Exact add, subtract, multiply, divide and compare on fractions, with the
// result reduced by the greatest common divisor.
// ----------------------------------------------------------------------------
// An item enters on the req_ channel: the operation code in req_tuser and the
// two fractions in req_tdata. Each item gives one item on the rsp_ channel:
// the reduced fraction and the compare flags in rsp_tdata, the status in
// rsp_tuser. Operands are taken at WORD_WIDTH bits.
// One item is worked on at a time; req_tready is high only while the
// sequencer is idle. For invalid codes and zero denominators the result is
// loaded in the emit state straight after decode; a compare passes decode
// and the P and Q products first. Arithmetic takes three passes of the shared
// multiplier, a binary GCD loop of up to 4*WORD_WIDTH steps (one step a cycle,
// set by the size of the double-width products) and 2*WORD_WIDTH division
// steps that reduce numerator and denominator together. req_tready returns in
// the cycle after the result is loaded. The result sits in an output register,
// so the next item is accepted while a result waits; a stalled receiver holds
// rsp_tdata and rsp_tuser and stops the following item only when its own
// result is ready.
// Reset clears the sequencer, holds req_tready low and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module rational_arith_unit_top #(
   parameter int WORD_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // a_num, a_den, b_num, b_den
   input  logic [2:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // res_num, res_den, is_equal, is_less, zero fill
   output logic [1:0]   rsp_tuser   // status
);

   rau_pkg::cmd_type  cmd;
   rau_pkg::stat_type stat;

   rau_ctrl #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rau_datapath #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_error_clears_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != rau_pkg::ST_OK) |-> (rsp_tdata == '0))
      else $error("Error status carries a non-zero result.");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("A second item was accepted while one is in work.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[64] && rsp_tdata[65]))
      else $error("Equal and less flags are both set.");

   a_arith_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[63:32] != 32'd0) |-> (rsp_tdata[65:64] == 2'b00))
      else $error("An arithmetic result carries compare flags.");
`endif

endmodule

### verif/rational_arith_unit_top_tb.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_top_tb
// Self-checking bench for the fraction arithmetic unit. A short table of
// directed items covers the extremes, every operation and the error cases.
// A long run of random items follows, many of them built as related pairs so
// that reductions, equal compares and zero sums are frequent. Both channels
// idle at random. Every result is checked field by field against its table entry
// or a predictor that computes the reduced fraction with 64-bit integers.
// ----------------------------------------------------------------------------
module rational_arith_unit_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_WIDTH = 32;
   localparam int RANDOM_ITEMS = 1025;
   localparam int QUIET_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 250;

   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
   } req_item_type;

   typedef struct packed {
      logic [31:0] res_num;
      logic [31:0] res_den;
      logic        is_equal;
      logic        is_less;
      logic [1:0]  status;
   } rsp_item_type;

   typedef struct {
      req_item_type req;
      bit           typed;
      rsp_item_type want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   rsp_item_type results_due[$];
   int           errors = 0;
   int           quiet_cycles = 0;
   bit           calm = 1'b0;

   stim_row_type directed_rows [25] = '{
      '{'{rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b1,
        '{32'd5, 32'd6, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b1,
        '{32'd1, 32'd6, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4}, 1'b1,
        '{32'd1, 32'd2, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_DIV, 32'd1, 32'd2, -32'sd1, 32'd4}, 1'b1,
        '{-32'sd2, 32'd1, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_CMP, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_CMP, 32'd1, 32'd3, 32'd2, 32'd6}, 1'b1,
        '{32'd0, 32'd0, 1'b1, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_CMP, -32'sd1, 32'd2, 32'd1, 32'd3}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b1, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_DIVZERO}},
      '{'{rau_pkg::OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_DIVZERO}},
      '{'{rau_pkg::OP_DIV, 32'd1, 32'd1, 32'd0, 32'd5}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_DIVZERO}},
      '{'{OP_SPARE5, 32'd3, 32'd4, 32'd5, 32'd6}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{OP_SPARE6, 32'd3, 32'd0, 32'd5, 32'd0}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{OP_SPARE7, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_ADD, 32'd0, 32'd5, 32'd0, 32'd7}, 1'b1,
        '{32'd0, 32'd1, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, -32'sd1, 32'd1}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_OVERFLOW}},
      '{'{rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1}, 1'b1,
        '{32'h8000_0000, 32'd1, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_MUL, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd2}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_OVERFLOW}},
      '{'{rau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1}, 1'b1,
        '{32'd0, 32'd0, 1'b0, 1'b0, rau_pkg::ST_OVERFLOW}},
      '{'{rau_pkg::OP_DIV, -32'sd3, 32'd4, -32'sd9, 32'd8}, 1'b1,
        '{32'd2, 32'd3, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_ADD, -32'sd1, 32'd1, 32'd1, 32'd1}, 1'b1,
        '{32'd0, 32'd1, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE},
        1'b0, '0},
      '{'{rau_pkg::OP_SUB, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1},
        1'b0, '0},
      '{'{rau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
        1'b0, '0},
      '{'{rau_pkg::OP_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
        1'b0, '0},
      '{'{rau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0},
        1'b0, '0}
   };

   rational_arith_unit_top #(
      .WORD_WIDTH(WORD_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit [63:0] common_divisor(bit [63:0] x, bit [63:0] y);
      bit [63:0] t;
      while (y != 64'd0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic rsp_item_type reduced_fraction(bit neg, bit [63:0] mag,
                                                     bit [63:0] den);
      rsp_item_type o;
      bit [63:0] g;
      o = '0;
      g = common_divisor(mag, den);
      mag = mag / g;
      den = den / g;
      if (mag == 64'd0)
         neg = 1'b0;
      if ((neg ? mag > 64'h8000_0000 : mag > 64'h7FFF_FFFF) || den > 64'hFFFF_FFFF) begin
         o.status = rau_pkg::ST_OVERFLOW;
         return o;
      end
      o.res_num = mag[31:0];
      if (neg)
         o.res_num = -o.res_num;
      o.res_den = den[31:0];
      o.status = rau_pkg::ST_OK;
      return o;
   endfunction

   function automatic rsp_item_type fraction_result(req_item_type it);
      rsp_item_type o;
      longint an, bn, lhs, rhs;
      bit [63:0] am, bm, ad, bd, p, q;
      bit a_neg, b_neg, q_neg;
      o = '0;
      an = $signed(it.a_num);
      bn = $signed(it.b_num);
      ad = it.a_den;
      bd = it.b_den;
      a_neg = an < 0;
      b_neg = bn < 0;
      am = a_neg ? -an : an;
      bm = b_neg ? -bn : bn;
      if (it.op > rau_pkg::OP_CMP)
         return o;
      if (ad == 64'd0 || bd == 64'd0) begin
         o.status = rau_pkg::ST_DIVZERO;
         return o;
      end
      case (it.op)
         rau_pkg::OP_CMP: begin
            lhs = an * longint'(bd);
            rhs = bn * longint'(ad);
            o.is_equal = lhs == rhs;
            o.is_less = lhs < rhs;
         end
         rau_pkg::OP_MUL: o = reduced_fraction(a_neg != b_neg, am * bm, ad * bd);
         rau_pkg::OP_DIV: begin
            if (bm == 64'd0)
               o.status = rau_pkg::ST_DIVZERO;
            else
               o = reduced_fraction(a_neg != b_neg, am * bd, ad * bm);
         end
         default: begin
            p = am * bd;
            q = bm * ad;
            q_neg = (it.op == rau_pkg::OP_SUB) ? !b_neg : b_neg;
            if (a_neg == q_neg)
               o = reduced_fraction(a_neg, p + q, ad * bd);
            else if (p >= q)
               o = reduced_fraction(a_neg, p - q, ad * bd);
            else
               o = reduced_fraction(q_neg, q - p, ad * bd);
         end
      endcase
      return o;
   endfunction

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] random_num();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v = $urandom_range(0, 40);
            return v - 20;
         end
         4, 5: begin
            v = $urandom_range(0, 2000000);
            return v - 1000000;
         end
         6, 7: return $urandom();
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] random_den();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return $urandom_range(1, 40);
         7: return $urandom_range(1, 65535);
         8: return $urandom();
         default: begin
            case ($urandom_range(0, 2))
               0: return 32'hFFFF_FFFF;
               1: return 32'h8000_0000;
               default: return 32'd1;
            endcase
         end
      endcase
   endfunction

   function automatic req_item_type random_request();
      req_item_type it;
      int v, k;
      if ($urandom_range(0, 99) < 92)
         it.op = 3'($urandom_range(rau_pkg::OP_ADD, rau_pkg::OP_CMP));
      else
         it.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
      if ($urandom_range(0, 3) == 0) begin
         v = $urandom_range(0, 60);
         v = v - 30;
         k = $urandom_range(1, 12);
         it.a_num = v;
         it.a_den = $urandom_range(1, 40);
         it.b_num = v * k;
         if ($urandom_range(0, 3) == 0)
            it.b_num = it.b_num + $urandom_range(0, 2) - 1;
         if ($urandom_range(0, 1) == 1)
            it.b_num = -it.b_num;
         it.b_den = it.a_den * k;
      end else begin
         it.a_num = random_num();
         it.a_den = random_den();
         it.b_num = random_num();
         it.b_den = random_den();
      end
      if ($urandom_range(0, 49) == 0)
         it.a_den = '0;
      if ($urandom_range(0, 49) == 0)
         it.b_den = '0;
      return it;
   endfunction

   task automatic report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(req_item_type it, bit typed, rsp_item_type want);
      int gap;
      gap = calm ? 0 : idle_cycles();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = it.op;
      req_tdata = {it.b_den, it.b_num, it.a_den, it.a_num};
      do
         @(posedge clock);
      while (!req_tready);
      results_due.push_back(typed ? want : fraction_result(it));
      @(negedge clock);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = ((n / 64) % 4) == 1;
         send_request(random_request(), 1'b0, '0);
      end
      calm = 1'b0;
      req_tvalid = 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : receiver
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else begin
            hold = calm ? 0 : idle_cycles();
            rsp_tready = hold == 0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            report("result item with no request outstanding");
         end else begin
            want = results_due.pop_front();
            if (rsp_tdata[31:0] !== want.res_num)
               report($sformatf("res_num %h, expected %h", rsp_tdata[31:0], want.res_num));
            if (rsp_tdata[63:32] !== want.res_den)
               report($sformatf("res_den %h, expected %h", rsp_tdata[63:32], want.res_den));
            if (rsp_tdata[64] !== want.is_equal)
               report($sformatf("is_equal %b, expected %b", rsp_tdata[64], want.is_equal));
            if (rsp_tdata[65] !== want.is_less)
               report($sformatf("is_less %b, expected %b", rsp_tdata[65], want.is_less));
            if (rsp_tuser !== want.status)
               report($sformatf("status %0d, expected %0d", rsp_tuser, want.status));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
